// ----- hw/rtl/bbff_pkg.sv -----
// ----------------------------------------------------------------------------
// bbff_pkg
// Shared widths, types and reset values of the byte-budgeted frame FIFO.
// ----------------------------------------------------------------------------
package bbff_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned SIZE_W   = 40;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned TAG_W    = 32;

  localparam logic [SIZE_W-1:0] BUDGET_RST = SIZE_W'(268435456);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic              sub;
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
  } alu_req_t;

endpackage

// ----- hw/rtl/bbff_intf.sv -----
// ----------------------------------------------------------------------------
// bbff channel interfaces
// Valid/ready channels for requests, results and the budget register write.
// ----------------------------------------------------------------------------
interface bbff_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [bbff_pkg::SIZE_W-1:0]   frame_bytes;
  logic [bbff_pkg::HANDLE_W-1:0] frame_handle;
  logic [bbff_pkg::TAG_W-1:0]    desc_tag;

  modport source (output valid, opcode, frame_bytes, frame_handle, desc_tag,
                  input ready);
  modport sink (input valid, opcode, frame_bytes, frame_handle, desc_tag,
                output ready);
endinterface

interface bbff_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [bbff_pkg::CNT_W-1:0]    evicted_count;
  logic [bbff_pkg::HANDLE_W-1:0] taken_handle;
  logic [bbff_pkg::CNT_W-1:0]    frame_count;
  logic [bbff_pkg::SIZE_W-1:0]   total_bytes;

  modport source (output valid, accepted, evicted_count, taken_handle,
                  frame_count, total_bytes, input ready);
  modport sink (input valid, accepted, evicted_count, taken_handle,
                frame_count, total_bytes, output ready);
endinterface

interface bbff_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bbff_pkg::SIZE_W-1:0] byte_budget;

  modport source (output valid, byte_budget, input ready);
  modport sink (input valid, byte_budget, output ready);
endinterface

// ----- hw/rtl/byte_budget_frame_fifo_core.sv -----
// ----------------------------------------------------------------------------
// byte_budget_frame_fifo_core
// FIFO of frames kept under a byte budget, with oldest-first eviction and
// tag-matched reuse of the oldest frame.
// ----------------------------------------------------------------------------
// One request is worked at a time by a sequencer around a single 40-bit
// add/subtract unit; each arithmetic step and each pop has a state of its own.
// A refused request goes from check to done; a take goes through check and
// compare, and through pop when the frame is taken; an add goes through check,
// then compare and pop once per frame popped to make room, compare and append.
// A result waits in done while a full output register has not drained. The
// input is ready again in the cycle the result appears. A finished result sits
// in the output register, so the next request is taken while it waits. The
// byte budget resets to 256 MiB; the user must write it through the config
// channel only while no request is in flight; the block does not enforce it.
module byte_budget_frame_fifo_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbff_in_if.sink    in_i,
  bbff_out_if.source out_o,
  bbff_cfg_if.sink   cfg_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_POP    = 3'd3;
  localparam logic [2:0] ST_APPEND = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [bbff_pkg::SIZE_W-1:0]   budget_q;
  logic [bbff_pkg::IDX_W-1:0]    head_q, head_d;
  logic [bbff_pkg::CNT_W-1:0]    count_q, count_d;
  logic [bbff_pkg::SIZE_W-1:0]   held_q, held_d;

  logic                          op_q;
  logic [bbff_pkg::SIZE_W-1:0]   size_q;
  logic [bbff_pkg::HANDLE_W-1:0] handle_q;
  logic [bbff_pkg::TAG_W-1:0]    tag_q;
  logic [bbff_pkg::SIZE_W-1:0]   rem_q, rem_d;
  logic                          acc_q, acc_d;
  logic [bbff_pkg::CNT_W-1:0]    evict_q, evict_d;
  logic [bbff_pkg::HANDLE_W-1:0] taken_q, taken_d;

  logic                          out_valid_q;
  logic                          res_acc_q;
  logic [bbff_pkg::CNT_W-1:0]    res_evict_q;
  logic [bbff_pkg::HANDLE_W-1:0] res_taken_q;
  logic [bbff_pkg::CNT_W-1:0]    res_count_q;
  logic [bbff_pkg::SIZE_W-1:0]   res_bytes_q;

  bbff_pkg::alu_req_t            alu_req;
  logic [bbff_pkg::SIZE_W-1:0]   alu_res;
  logic                          alu_borrow;

  logic                          wr_en;
  logic [bbff_pkg::IDX_W-1:0]    tail;
  bbff_pkg::entry_t              wr_data;
  bbff_pkg::entry_t              head_entry;

  logic in_xfer;
  logic res_load;
  logic not_empty;
  logic full;

  bbff_alu u_alu (
    .req_i    (alu_req),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  bbff_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail),
    .wr_data_i (wr_data),
    .rd_addr_i (head_d),
    .rd_data_o (head_entry)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign not_empty   = (count_q != '0);
  assign full        = (count_q == bbff_pkg::CNT_W'(bbff_pkg::DEPTH));
  assign tail        = head_q + count_q[bbff_pkg::IDX_W-1:0];
  assign res_load    = (state_q == ST_DONE) & (~out_valid_q | out_o.ready);

  assign wr_en   = (state_q == ST_APPEND);
  assign wr_data = '{size: size_q, handle: handle_q, tag: tag_q};

  always_comb begin
    alu_req = '{sub: 1'b1, a: budget_q, b: size_q};
    case (state_q)
      ST_CMP:    alu_req = '{sub: 1'b1, a: rem_q, b: held_q};
      ST_POP:    alu_req = '{sub: 1'b1, a: held_q, b: head_entry.size};
      ST_APPEND: alu_req = '{sub: 1'b0, a: held_q, b: size_q};
      default:   alu_req = '{sub: 1'b1, a: budget_q, b: size_q};
    endcase
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    held_d  = held_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    evict_d = evict_q;
    taken_d = taken_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d   = 1'b0;
          evict_d = '0;
          taken_d = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rem_d = alu_res;
        if ((size_q == '0) || alu_borrow) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (op_q == bbff_pkg::OP_TAKE) begin
          if (not_empty && alu_borrow && (head_entry.tag == tag_q)) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_DONE;
          end
        end else if ((not_empty && alu_borrow) || full) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_POP: begin
        held_d  = alu_res;
        head_d  = head_q + 1'b1;
        count_d = count_q - 1'b1;
        if (op_q == bbff_pkg::OP_TAKE) begin
          taken_d = head_entry.handle;
          acc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          evict_d = evict_q + 1'b1;
          state_d = ST_CMP;
        end
      end
      ST_APPEND: begin
        held_d  = alu_res;
        count_d = count_q + 1'b1;
        acc_d   = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      budget_q    <= bbff_pkg::BUDGET_RST;
      head_q      <= '0;
      count_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      held_q  <= held_d;
      if (cfg_i.valid && cfg_i.ready) begin
        budget_q <= cfg_i.byte_budget;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    evict_q <= evict_d;
    taken_q <= taken_d;
    if (in_xfer) begin
      op_q     <= in_i.opcode;
      size_q   <= in_i.frame_bytes;
      handle_q <= in_i.frame_handle;
      tag_q    <= in_i.desc_tag;
    end
    if (res_load) begin
      res_acc_q   <= acc_q;
      res_evict_q <= evict_q;
      res_taken_q <= taken_q;
      res_count_q <= count_q;
      res_bytes_q <= held_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = res_acc_q;
  assign out_o.evicted_count = res_evict_q;
  assign out_o.taken_handle  = res_taken_q;
  assign out_o.frame_count   = res_count_q;
  assign out_o.total_bytes   = res_bytes_q;

endmodule

// ----- hw/rtl/bbff_ram.sv -----
// ----------------------------------------------------------------------------
// bbff_ram
// Frame entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbff_ram (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [bbff_pkg::IDX_W-1:0]  wr_addr_i,
  input  bbff_pkg::entry_t            wr_data_i,
  input  logic [bbff_pkg::IDX_W-1:0]  rd_addr_i,
  output bbff_pkg::entry_t            rd_data_o
);

  bbff_pkg::entry_t mem_q [bbff_pkg::DEPTH];
  bbff_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/bbff_alu.sv -----
// ----------------------------------------------------------------------------
// bbff_alu
// Shared byte-count adder/subtractor; on a subtract the carry-out bit flags a borrow.
// ----------------------------------------------------------------------------
module bbff_alu (
  input  bbff_pkg::alu_req_t          req_i,
  output logic [bbff_pkg::SIZE_W-1:0] res_o,
  output logic                        borrow_o
);

  logic [bbff_pkg::SIZE_W:0] sum;

  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

  assign res_o    = sum[bbff_pkg::SIZE_W-1:0];
  assign borrow_o = req_i.sub & sum[bbff_pkg::SIZE_W];

endmodule
